FILE: rtl/tilt_pkg.sv
package tilt_pkg;

  // Field and register widths.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned DIFF_W    = 17;
  localparam int unsigned ANG_W     = 17;
  localparam int unsigned CFG_IDX_W = 1;

  // CORDIC datapath: vector components prescaled by 2^12, angles in 1/65536 degree.
  localparam int unsigned PRESCALE  = 12;
  localparam int unsigned XW        = 32;
  localparam int unsigned AW        = 26;
  localparam int unsigned ATAN_W    = 22;
  localparam int unsigned TAB_IDX_W = 5;

  localparam int DEG90_Q16 = 90 * 65536;
  localparam int ANG180_Q8 = 46080;
  localparam int ANG90_Q8  = 23040;

  // Defaults for the top-level parameters.
  localparam int unsigned SAMPLES_DEF = 5;
  localparam int unsigned STEPS_DEF   = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET = 1'b1;

  // Reset values of the offset registers.
  localparam logic signed [SAMPLE_W-1:0] Y_OFFSET_RST = 16'sd0;
  localparam logic signed [SAMPLE_W-1:0] Z_OFFSET_RST = -16'sd984;

  // atan(2^-i) in 1/65536 degree, rounded to nearest.
  function automatic logic [ATAN_W-1:0] atan_q16(input logic [TAB_IDX_W-1:0] idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/accel_tilt_angle_averager.sv
// The mean reaches the output register after the input transaction that closes a group
// has passed PREP, ROT, ROUND, ACCUM, NUMER, DIV and DONE. The input stays stalled until then,
// and longer if the previous mean still waits in the output register. Other transactions
// stall the input through PREP, ROT, ROUND and ACCUM, or PREP and ACCUM for an exact axis angle.
// The shared CORDIC unit takes a new input transaction only once it is through with the previous one.
// Reset (rst_n, synchronous, active low) clears sum, count, sequencer, output valid; offsets 0, -984.
module accel_tilt_angle_averager #(
  parameter int unsigned SAMPLES_PER_RESULT = tilt_pkg::SAMPLES_DEF,
  parameter int unsigned CORDIC_STEPS       = tilt_pkg::STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // Configuration write port.
  input  logic                                  cfg_we,
  input  logic [tilt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tilt_pkg::SAMPLE_W-1:0]         cfg_data,
  // Input channel.
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [tilt_pkg::SAMPLE_W-1:0]  in_accel_y,
  input  logic signed [tilt_pkg::SAMPLE_W-1:0]  in_accel_z,
  // Result channel.
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [tilt_pkg::ANG_W-1:0]     out_mean_angle
);

  localparam int unsigned DIFF_W = tilt_pkg::DIFF_W;
  localparam int unsigned ANG_W  = tilt_pkg::ANG_W;
  localparam int unsigned XW     = tilt_pkg::XW;
  localparam int unsigned AW     = tilt_pkg::AW;
  localparam int unsigned QW     = AW - 8;

  // The running sum holds at most SAMPLES_PER_RESULT full-scale angles.
  localparam int unsigned SUM_W  = $clog2(SAMPLES_PER_RESULT * 46080 + 1) + 1;
  localparam int unsigned CNT_W  = $clog2(SAMPLES_PER_RESULT + 1);
  localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);
  // Rounded mean = (2*|sum| + N) / (2*N), by multiplying with a rounded-up reciprocal.
  // With RSH = NUM_W + DEN_W fraction bits the truncated product is the exact quotient
  // for every numerator that fits in NUM_W bits.
  localparam int unsigned DEN    = 2 * SAMPLES_PER_RESULT;
  localparam int unsigned NUM_W  = $clog2(SAMPLES_PER_RESULT * 92161 + 1);
  localparam int unsigned DEN_W  = $clog2(DEN);
  localparam int unsigned RSH    = NUM_W + DEN_W;
  localparam int unsigned RCP_W  = NUM_W + 2;
  localparam int unsigned PROD_W = NUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RSH) + 64'(DEN) - 64'd1) / 64'(DEN));

  localparam logic signed [QW-1:0]    Q8_HI = QW'(tilt_pkg::ANG180_Q8);
  localparam logic signed [QW-1:0]    Q8_LO = -QW'(tilt_pkg::ANG180_Q8);
  localparam logic signed [AW-1:0]    ACC_90 = AW'(tilt_pkg::DEG90_Q16);
  localparam logic signed [ANG_W-1:0] ANG_180 = ANG_W'(tilt_pkg::ANG180_Q8);
  localparam logic signed [ANG_W-1:0] ANG_90 = ANG_W'(tilt_pkg::ANG90_Q8);

  // Sequencer. PREP sorts out the exact special cases and the quadrant pre-rotation,
  // ROT runs the micro-rotations, ROUND takes the angle to 1/256 degree, ACCUM adds it
  // to the sum, NUMER forms the division numerator, DIV multiplies it by the reciprocal,
  // DONE hands the mean to the output register once that register is free.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PREP  = 8'b0000_0010,
    ST_ROT   = 8'b0000_0100,
    ST_ROUND = 8'b0000_1000,
    ST_ACCUM = 8'b0001_0000,
    ST_NUMER = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Control state (reset).
  logic signed [tilt_pkg::SAMPLE_W-1:0] y_offset_r, y_offset_nxt;
  logic signed [tilt_pkg::SAMPLE_W-1:0] z_offset_r, z_offset_nxt;
  logic signed [SUM_W-1:0]              sum_r, sum_nxt;
  logic [CNT_W-1:0]                     count_r, count_nxt;
  logic                                 out_valid_r, out_valid_nxt;

  // Datapath registers (no reset).
  logic signed [DIFF_W-1:0] dy_r, dy_nxt;
  logic signed [DIFF_W-1:0] dz_r, dz_nxt;
  logic signed [XW-1:0]     x_r, x_nxt;
  logic signed [XW-1:0]     w_r, w_nxt;
  logic signed [AW-1:0]     acc_r, acc_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic signed [ANG_W-1:0]  angle_r, angle_nxt;
  logic                     neg_r, neg_nxt;
  logic [NUM_W-1:0]         num_r, num_nxt;
  logic signed [ANG_W-1:0]  mean_r, mean_nxt;

  // Shared CORDIC rotation unit.
  logic signed [XW-1:0] dx, dw;
  logic signed [AW-1:0] atan_s;
  logic signed [XW-1:0] x_pre, w_pre;

  // Rounding and accumulation.
  logic signed [AW-1:0] acc_rnd;
  logic signed [QW-1:0] q8;
  logic [CNT_W:0]       count_inc;
  logic [SUM_W-1:0]     sum_mag;

  // Division by the constant 2*N.
  logic [PROD_W-1:0]    prod;
  logic [ANG_W-1:0]     quot;

  assign x_pre = XW'(dz_r) <<< tilt_pkg::PRESCALE;
  assign w_pre = XW'(dy_r) <<< tilt_pkg::PRESCALE;

  // Arithmetic shifts floor toward minus infinity, as the micro-rotations require.
  assign dx     = w_r >>> step_r;
  assign dw     = x_r >>> step_r;
  assign atan_s = AW'($signed({1'b0, tilt_pkg::atan_q16(tilt_pkg::TAB_IDX_W'(step_r))}));

  assign acc_rnd = acc_r + AW'(128);
  assign q8      = $signed(acc_rnd[AW-1:8]);

  assign count_inc = (CNT_W+1)'(count_r) + (CNT_W+1)'(1);
  assign sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  assign prod = PROD_W'(num_r) * PROD_W'(RECIP);
  assign quot = num_r[ANG_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    y_offset_nxt  = y_offset_r;
    z_offset_nxt  = z_offset_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & out_stall;
    dy_nxt        = dy_r;
    dz_nxt        = dz_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    acc_nxt       = acc_r;
    step_nxt      = step_r;
    angle_nxt     = angle_r;
    neg_nxt       = neg_r;
    num_nxt       = num_r;
    mean_nxt      = mean_r;

    // User must change offsets only while idle (block does not enforce it); they apply at once.
    if (cfg_we) begin
      unique case (cfg_index)
        tilt_pkg::REG_Y_OFFSET: y_offset_nxt = $signed(cfg_data);
        tilt_pkg::REG_Z_OFFSET: z_offset_nxt = $signed(cfg_data);
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // 17-bit differences never wrap.
          dy_nxt    = DIFF_W'(in_accel_y) - DIFF_W'(y_offset_r);
          dz_nxt    = DIFF_W'(in_accel_z) - DIFF_W'(z_offset_r);
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        step_nxt = '0;
        if (dy_r == '0) begin
          // On the Z axis the angle is exact: 0 or +180 degrees.
          angle_nxt = dz_r[DIFF_W-1] ? ANG_180 : '0;
          state_nxt = ST_ACCUM;
        end else if (dz_r == '0) begin
          angle_nxt = dy_r[DIFF_W-1] ? -ANG_90 : ANG_90;
          state_nxt = ST_ACCUM;
        end else begin
          // Left half-plane vectors are turned by 90 degrees so the CORDIC converges.
          if (dz_r[DIFF_W-1]) begin
            if (!dy_r[DIFF_W-1]) begin
              x_nxt   = w_pre;
              w_nxt   = -x_pre;
              acc_nxt = ACC_90;
            end else begin
              x_nxt   = -w_pre;
              w_nxt   = x_pre;
              acc_nxt = -ACC_90;
            end
          end else begin
            x_nxt   = x_pre;
            w_nxt   = w_pre;
            acc_nxt = '0;
          end
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        if (!w_r[XW-1]) begin
          x_nxt   = x_r + dx;
          w_nxt   = w_r - dw;
          acc_nxt = acc_r + atan_s;
        end else begin
          x_nxt   = x_r - dx;
          w_nxt   = w_r + dw;
          acc_nxt = acc_r - atan_s;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        // Round half up to 1/256 degree and clamp to +-180 degrees.
        if (q8 > Q8_HI) begin
          angle_nxt = ANG_W'(Q8_HI);
        end else if (q8 < Q8_LO) begin
          angle_nxt = ANG_W'(Q8_LO);
        end else begin
          angle_nxt = ANG_W'(q8);
        end
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        sum_nxt = sum_r + SUM_W'(angle_r);
        if (count_inc >= (CNT_W+1)'(SAMPLES_PER_RESULT)) begin
          state_nxt = ST_NUMER;
        end else begin
          count_nxt = CNT_W'(count_inc);
          state_nxt = ST_IDLE;
        end
      end
      ST_NUMER: begin
        neg_nxt   = sum_r[SUM_W-1];
        num_nxt   = NUM_W'({sum_mag, 1'b0}) + NUM_W'(SAMPLES_PER_RESULT);
        sum_nxt   = '0;
        count_nxt = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // The quotient replaces the numerator; the fraction bits of the product are dropped.
        num_nxt   = NUM_W'(prod[RSH +: ANG_W]);
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // Ties were rounded away from zero on the magnitude; the sign goes back on here.
        if (!out_valid_r || !out_stall) begin
          mean_nxt      = neg_r ? -$signed(quot) : $signed(quot);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      y_offset_r  <= tilt_pkg::Y_OFFSET_RST;
      z_offset_r  <= tilt_pkg::Z_OFFSET_RST;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      y_offset_r  <= y_offset_nxt;
      z_offset_r  <= z_offset_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dy_r    <= dy_nxt;
    dz_r    <= dz_nxt;
    x_r     <= x_nxt;
    w_r     <= w_nxt;
    acc_r   <= acc_nxt;
    step_r  <= step_nxt;
    angle_r <= angle_nxt;
    neg_r   <= neg_nxt;
    num_r   <= num_nxt;
    mean_r  <= mean_nxt;
  end

  // A new input transaction is taken only by the idle sequencer; a result waiting in the
  // output register holds it off while the sequencer waits in DONE for that register.
  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_mean_angle = mean_r;

`ifndef NO_ASSERTIONS
  // A result is only ever loaded from the end of the division.
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("output valid rose outside the division end");

  // The group count never reaches the group size between transactions.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < CNT_W'(SAMPLES_PER_RESULT))
    else $error("sample count reached the group size");

  // After pre-rotation the CORDIC x component stays non-negative.
  a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROT |-> !x_r[XW-1])
    else $error("CORDIC x component went negative");

  // Sum and count are cleared together when a group closes.
  a_group_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_NUMER |=> (sum_r == '0 && count_r == '0))
    else $error("sum or count not cleared after a group");
`endif

endmodule
